// File: rtl/rrc_pkg.sv
// shared types, codes and constants of the rebuild recovery and retry controller
package rrc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned GEN_W     = 32;
  localparam int unsigned LIMIT_W   = 8;
  localparam int unsigned ATTEMPT_W = 8;
  localparam int unsigned REASON_W  = 3;
  localparam int unsigned CR_W      = 4;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned NUM_CNT   = 6;
  localparam int unsigned CNT_IDX_W = 3;
  localparam int unsigned SHIFT_W   = $clog2(TIME_W);

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 4;
  localparam int unsigned OUT_DATA_W = 152;

  localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX = '1;

  typedef enum logic [2:0] {
    MODE_READY     = 3'd0,
    MODE_INCR      = 3'd1,
    MODE_REQ       = 3'd2,
    MODE_FLIGHT    = 3'd3,
    MODE_BACKOFF   = 3'd4,
    MODE_DEGRADED  = 3'd5,
    MODE_SUSPENDED = 3'd6
  } mode_e;

  typedef enum logic [3:0] {
    EV_RESET      = 4'd0,
    EV_INVALIDATE = 4'd1,
    EV_REQUEST    = 4'd2,
    EV_INCR_PEND  = 4'd3,
    EV_INCR_OK    = 4'd4,
    EV_TRY_BEGIN  = 4'd5,
    EV_SUCCEEDED  = 4'd6,
    EV_FAILURE    = 4'd7,
    EV_COMMIT     = 4'd8,
    EV_STALE      = 4'd9,
    EV_SUSPEND    = 4'd10,
    EV_RESUME     = 4'd11
  } kind_e;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_DROP     = 2'd1,
    ACT_RETRY    = 2'd2,
    ACT_DEGRADED = 2'd3
  } action_e;

  localparam logic [REASON_W-1:0] RSN_NONE      = 3'd0;
  localparam logic [REASON_W-1:0] RSN_WORKSPACE = 3'd1;
  localparam logic [REASON_W-1:0] RSN_RES_GEN   = 3'd2;
  localparam logic [REASON_W-1:0] RSN_DATA_REV  = 3'd3;
  localparam logic [REASON_W-1:0] RSN_SCHEDULER = 3'd4;
  localparam logic [REASON_W-1:0] RSN_PAYLOAD   = 3'd5;
  localparam logic [REASON_W-1:0] RSN_WORKER    = 3'd6;

  localparam logic [CR_W-1:0] CR_APPLIED     = 4'd0;
  localparam logic [CR_W-1:0] CR_STALE_A     = 4'd1;
  localparam logic [CR_W-1:0] CR_STALE_B     = 4'd2;
  localparam logic [CR_W-1:0] CR_STALE_C     = 4'd3;
  localparam logic [CR_W-1:0] CR_STALE_D     = 4'd4;
  localparam logic [CR_W-1:0] CR_WORKSPACE_A = 4'd5;
  localparam logic [CR_W-1:0] CR_WORKSPACE_B = 4'd6;
  localparam logic [CR_W-1:0] CR_RES_GEN     = 4'd7;
  localparam logic [CR_W-1:0] CR_DATA_REV    = 4'd8;
  localparam logic [CR_W-1:0] CR_DESCRIPTOR  = 4'd9;
  localparam logic [CR_W-1:0] CR_PAYLOAD     = 4'd10;

  localparam logic [CNT_IDX_W-1:0] CNT_REQ      = 3'd0;
  localparam logic [CNT_IDX_W-1:0] CNT_ATTEMPT  = 3'd1;
  localparam logic [CNT_IDX_W-1:0] CNT_RETRY    = 3'd2;
  localparam logic [CNT_IDX_W-1:0] CNT_DEGRADED = 3'd3;
  localparam logic [CNT_IDX_W-1:0] CNT_SOFT     = 3'd4;
  localparam logic [CNT_IDX_W-1:0] CNT_STALE    = 3'd5;

  localparam logic [REG_IDX_W-1:0] REG_WS_LIMIT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCHED_LIMIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAY_LIMIT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRK_LIMIT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INIT_BO     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MAX_BO      = 3'd5;

  typedef struct packed {
    logic [LIMIT_W-1:0] ws_limit;
    logic [LIMIT_W-1:0] sched_limit;
    logic [LIMIT_W-1:0] payload_limit;
    logic [LIMIT_W-1:0] worker_limit;
    logic [TIME_W-1:0]  init_backoff;
    logic [TIME_W-1:0]  max_backoff;
  } cfg_t;

  typedef struct packed {
    logic [3:0]          kind;
    logic [REASON_W-1:0] reason;
    logic [CR_W-1:0]     commit_result;
    logic [TIME_W-1:0]   current_time;
    logic                option_flag;
    logic [SEL_W-1:0]    counter_select;
  } event_t;

  typedef struct packed {
    mode_e                mode;
    action_e              action;
    logic                 began;
    logic                 retry_due;
    logic                 needs_rebuild;
    logic [GEN_W-1:0]     generation;
    logic [GEN_W-1:0]     last_good_generation;
    logic [ATTEMPT_W-1:0] attempts;
    logic [REASON_W-1:0]  last_reason;
    logic [TIME_W-1:0]    retry_time;
    logic                 rebuild_after_resume;
    logic [COUNT_W-1:0]   counter_value;
  } result_t;

  function automatic logic is_rebuild_mode(mode_e m);
    return (m == MODE_REQ) || (m == MODE_FLIGHT) || (m == MODE_BACKOFF);
  endfunction

endpackage

// File: rtl/rrc_core.sv
// controller state, event decode, retry backoff and diagnostic counters
module rrc_core
  import rrc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  event_t  ev_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  mode_e                mode_q, mode_d;
  logic [GEN_W-1:0]     gen_q, gen_d;
  logic [GEN_W-1:0]     good_q, good_d;
  logic [REASON_W-1:0]  reason_q, reason_d;
  logic [ATTEMPT_W-1:0] att_q, att_d;
  logic [TIME_W-1:0]    retry_q, retry_d;
  logic                 pend_q, pend_d;
  logic [COUNT_W-1:0]   cnt_q [NUM_CNT];
  logic [COUNT_W-1:0]   cnt_d [NUM_CNT];
  logic [NUM_CNT-1:0]   inc;

  logic                 fail_req;
  logic [REASON_W-1:0]  fail_reason;
  logic [LIMIT_W-1:0]   limit;
  logic                 do_succeed;
  logic                 do_stale;
  action_e              action;
  logic                 began;

  logic [ATTEMPT_W-1:0] shift_amt;
  logic [2*TIME_W-1:0]  shifted;
  logic [TIME_W-1:0]    backoff;
  logic [TIME_W:0]      due_sum;
  logic [TIME_W-1:0]    due_time;

  // backoff = min(max, init << (attempts - 1))
  always_comb begin
    shift_amt = (att_q != '0) ? att_q - ATTEMPT_W'(1) : '0;
    shifted   = {{TIME_W{1'b0}}, cfg_i.init_backoff} << shift_amt[SHIFT_W-1:0];
    if (cfg_i.init_backoff == '0) begin
      backoff = '0;
    end else if (shift_amt >= ATTEMPT_W'(TIME_W)) begin
      backoff = cfg_i.max_backoff;
    end else if (shifted < {{TIME_W{1'b0}}, cfg_i.max_backoff}) begin
      backoff = shifted[TIME_W-1:0];
    end else begin
      backoff = cfg_i.max_backoff;
    end
    due_sum  = {1'b0, ev_i.current_time} + {1'b0, backoff};
    due_time = due_sum[TIME_W] ? '1 : due_sum[TIME_W-1:0];
  end

  always_comb begin
    case (fail_reason)
      RSN_WORKSPACE, RSN_RES_GEN, RSN_DATA_REV: limit = cfg_i.ws_limit;
      RSN_SCHEDULER:                            limit = cfg_i.sched_limit;
      RSN_PAYLOAD:                              limit = cfg_i.payload_limit;
      default:                                  limit = cfg_i.worker_limit;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    gen_d       = gen_q;
    good_d      = good_q;
    reason_d    = reason_q;
    att_d       = att_q;
    retry_d     = retry_q;
    pend_d      = pend_q;
    inc         = '0;
    fail_req    = 1'b0;
    fail_reason = ev_i.reason;
    do_succeed  = 1'b0;
    do_stale    = 1'b0;
    action      = ACT_NONE;
    began       = 1'b0;

    unique case (ev_i.kind)
      EV_RESET: begin
        if (ev_i.option_flag) gen_d = gen_q + GEN_W'(1);
        mode_d   = MODE_READY;
        reason_d = RSN_NONE;
        att_d    = '0;
        retry_d  = '0;
        pend_d   = 1'b0;
      end
      EV_INVALIDATE: begin
        gen_d    = gen_q + GEN_W'(1);
        att_d    = '0;
        retry_d  = '0;
        reason_d = ev_i.reason;
        if (mode_q == MODE_SUSPENDED) begin
          pend_d = 1'b1;
        end else begin
          mode_d       = MODE_REQ;
          inc[CNT_REQ] = 1'b1;
        end
      end
      EV_REQUEST: begin
        reason_d = ev_i.reason;
        if (mode_q == MODE_SUSPENDED) begin
          pend_d = 1'b1;
        end else if (mode_q == MODE_READY || mode_q == MODE_INCR) begin
          mode_d       = MODE_REQ;
          inc[CNT_REQ] = 1'b1;
        end
      end
      EV_INCR_PEND: begin
        if (mode_q == MODE_READY) mode_d = MODE_INCR;
      end
      EV_INCR_OK: begin
        if (mode_q == MODE_INCR) begin
          mode_d = MODE_READY;
          good_d = gen_q;
        end
      end
      EV_TRY_BEGIN: begin
        if (mode_q == MODE_REQ ||
            (mode_q == MODE_BACKOFF && ev_i.current_time >= retry_q)) begin
          mode_d           = MODE_FLIGHT;
          retry_d          = '0;
          att_d            = (att_q != ATTEMPT_MAX) ? att_q + ATTEMPT_W'(1) : att_q;
          inc[CNT_ATTEMPT] = 1'b1;
          began            = 1'b1;
        end
      end
      EV_SUCCEEDED: do_succeed = 1'b1;
      EV_FAILURE:   fail_req   = 1'b1;
      EV_COMMIT: begin
        case (ev_i.commit_result)
          CR_APPLIED: do_succeed = 1'b1;
          CR_STALE_A, CR_STALE_B, CR_STALE_C, CR_STALE_D: begin
            do_stale = 1'b1;
            action   = ACT_DROP;
          end
          CR_WORKSPACE_A, CR_WORKSPACE_B: begin
            inc[CNT_SOFT] = 1'b1;
            fail_req      = 1'b1;
            fail_reason   = RSN_WORKSPACE;
          end
          CR_RES_GEN: begin
            inc[CNT_SOFT] = 1'b1;
            fail_req      = 1'b1;
            fail_reason   = RSN_RES_GEN;
          end
          CR_DATA_REV: begin
            fail_req    = 1'b1;
            fail_reason = RSN_DATA_REV;
          end
          CR_DESCRIPTOR, CR_PAYLOAD: begin
            fail_req    = 1'b1;
            fail_reason = RSN_PAYLOAD;
          end
          default: begin
            fail_req    = 1'b1;
            fail_reason = RSN_WORKER;
          end
        endcase
      end
      EV_STALE: do_stale = 1'b1;
      EV_SUSPEND: begin
        pend_d  = is_rebuild_mode(mode_q);
        mode_d  = MODE_SUSPENDED;
        retry_d = '0;
      end
      EV_RESUME: begin
        if (mode_q == MODE_SUSPENDED) begin
          if (ev_i.option_flag || pend_q) begin
            mode_d       = MODE_REQ;
            inc[CNT_REQ] = 1'b1;
          end else begin
            mode_d = MODE_READY;
          end
          pend_d = 1'b0;
        end
      end
      default: ;
    endcase

    if (do_succeed) begin
      mode_d   = MODE_READY;
      good_d   = gen_q;
      reason_d = RSN_NONE;
      att_d    = '0;
      retry_d  = '0;
      pend_d   = 1'b0;
    end

    if (do_stale) begin
      inc[CNT_STALE] = 1'b1;
      if (mode_q == MODE_FLIGHT) mode_d = MODE_READY;
    end

    // a zero limit also lands here since attempts >= 0
    if (fail_req) begin
      reason_d = fail_reason;
      if (att_q >= limit) begin
        mode_d            = MODE_DEGRADED;
        retry_d           = '0;
        inc[CNT_DEGRADED] = 1'b1;
        action            = ACT_DEGRADED;
      end else begin
        mode_d         = MODE_BACKOFF;
        retry_d        = due_time;
        inc[CNT_RETRY] = 1'b1;
        action         = ACT_RETRY;
      end
    end

    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_d[i] = cnt_q[i] + COUNT_W'(inc[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_READY;
      gen_q    <= '0;
      good_q   <= '0;
      reason_q <= RSN_NONE;
      att_q    <= '0;
      retry_q  <= '0;
      pend_q   <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      gen_q    <= gen_d;
      good_q   <= good_d;
      reason_q <= reason_d;
      att_q    <= att_d;
      retry_q  <= retry_d;
      pend_q   <= pend_d;
      for (int i = 0; i < NUM_CNT; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  always_comb begin
    res_o.mode                 = mode_d;
    res_o.action               = action;
    res_o.began                = began;
    res_o.retry_due            = (mode_d == MODE_BACKOFF) && (ev_i.current_time >= retry_d);
    res_o.needs_rebuild        = is_rebuild_mode(mode_d);
    res_o.generation           = gen_d;
    res_o.last_good_generation = good_d;
    res_o.attempts             = att_d;
    res_o.last_reason          = reason_d;
    res_o.retry_time           = retry_d;
    res_o.rebuild_after_resume = pend_d;
    res_o.counter_value        = (ev_i.counter_select < SEL_W'(NUM_CNT)) ?
                                 cnt_d[ev_i.counter_select[CNT_IDX_W-1:0]] : '0;
  end

endmodule

// File: rtl/rebuild_recovery_retry_controller_unit.sv
// top level: apb registers, event input register, core and status output register
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser kind, tdata event fields
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata status fields
//  apb       in   psel, penable, pwrite, pready  six config registers at 4*i
//
//  one event per cycle while m_axis_tready is high; an event is held in the
//  input register and its status word leaves from the output register.
//  state is updated as the event moves into the output register. a stalled
//  output register holds the input register, and s_axis_tready falls only
//  when both are full. reset clears all state, counters and config to their
//  reset values at once.
module rebuild_recovery_retry_controller_unit
  import rrc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // reason, commit_result, current_time, option_flag, counter_select, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // mode, action, began, retry_due, needs_rebuild, generation_out,
  // last_good_generation, attempts, last_reason_out, retry_time,
  // rebuild_after_resume, counter_value, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t                  cfg_q;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_wr;

  logic                  in_vld_q;
  event_t                ev_q;
  logic                  out_vld_q;
  result_t               res_q;
  result_t               res;
  logic                  step;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ws_limit      <= LIMIT_W'(3);
      cfg_q.sched_limit   <= LIMIT_W'(3);
      cfg_q.payload_limit <= LIMIT_W'(1);
      cfg_q.worker_limit  <= LIMIT_W'(3);
      cfg_q.init_backoff  <= TIME_W'(100);
      cfg_q.max_backoff   <= TIME_W'(10000);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WS_LIMIT:    cfg_q.ws_limit      <= pwdata[LIMIT_W-1:0];
        REG_SCHED_LIMIT: cfg_q.sched_limit   <= pwdata[LIMIT_W-1:0];
        REG_PAY_LIMIT:   cfg_q.payload_limit <= pwdata[LIMIT_W-1:0];
        REG_WRK_LIMIT:   cfg_q.worker_limit  <= pwdata[LIMIT_W-1:0];
        REG_INIT_BO:     cfg_q.init_backoff  <= pwdata[TIME_W-1:0];
        REG_MAX_BO:      cfg_q.max_backoff   <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WS_LIMIT:    prdata = APB_DATA_W'(cfg_q.ws_limit);
      REG_SCHED_LIMIT: prdata = APB_DATA_W'(cfg_q.sched_limit);
      REG_PAY_LIMIT:   prdata = APB_DATA_W'(cfg_q.payload_limit);
      REG_WRK_LIMIT:   prdata = APB_DATA_W'(cfg_q.worker_limit);
      REG_INIT_BO:     prdata = APB_DATA_W'(cfg_q.init_backoff);
      REG_MAX_BO:      prdata = APB_DATA_W'(cfg_q.max_backoff);
      default:         prdata = '0;
    endcase
  end

  assign step          = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ev_q.kind           <= s_axis_tuser[3:0];
      ev_q.reason         <= s_axis_tdata[2:0];
      ev_q.commit_result  <= s_axis_tdata[6:3];
      ev_q.current_time   <= s_axis_tdata[38:7];
      ev_q.option_flag    <= s_axis_tdata[39];
      ev_q.counter_select <= s_axis_tdata[42:40];
    end
    if (step) res_q <= res;
  end

  rrc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ev_i   (ev_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000,
                          res_q.counter_value,
                          res_q.rebuild_after_resume,
                          res_q.retry_time,
                          res_q.last_reason,
                          res_q.attempts,
                          res_q.last_good_generation,
                          res_q.generation,
                          res_q.needs_rebuild,
                          res_q.retry_due,
                          res_q.began,
                          res_q.action,
                          res_q.mode};

endmodule

// File: rtl/rrc_checker.sv
// port-level checks of the controller status words, bound to the top level
module rrc_checker
  import rrc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [2:0] mode;
  logic [1:0] action;

  assign mode   = m_axis_tdata[2:0];
  assign action = m_axis_tdata[4:3];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("status word changed while stalled");

  a_needs_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7] == (mode == MODE_REQ || mode == MODE_FLIGHT ||
                                          mode == MODE_BACKOFF))
    else $error("needs_rebuild disagrees with mode");

  a_began_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> mode == MODE_FLIGHT)
    else $error("began without rebuild in flight");

  a_retry_due_backoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> mode == MODE_BACKOFF)
    else $error("retry due outside backoff");

  a_action_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (action != ACT_RETRY || mode == MODE_BACKOFF) &&
                      (action != ACT_DEGRADED || mode == MODE_DEGRADED))
    else $error("action disagrees with mode");

endmodule

bind rebuild_recovery_retry_controller_unit rrc_checker u_rrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
